[rtl/core/rope_pkg.sv]
package rope_pkg;

  localparam int HeadPairsDef    = 64;
  localparam int MaxHeadsDef     = 64;
  localparam int PositionBitsDef = 16;
  localparam int CordicSteps     = 30;
  localparam logic signed [33:0] CordicStartX = 34'sd652032874;

  localparam logic KindRotate = 1'b0;
  localparam logic KindLoad   = 1'b1;

  localparam logic [0:0] RegKeyHeadCount = 1'b0;

  typedef struct packed {
    logic              kind;
    logic [15:0]       position;
    logic [5:0]        head_index;
    logic [5:0]        pair_index;
    logic [31:0]       freq_word;
    logic signed [31:0] query_first;
    logic signed [31:0] query_second;
    logic signed [31:0] key_first;
    logic signed [31:0] key_second;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] query_first_out;
    logic signed [31:0] query_second_out;
    logic signed [31:0] key_first_out;
    logic signed [31:0] key_second_out;
    logic               key_rotated;
  } out_item_t;

  // Operands carried along the CORDIC chain.
  typedef struct packed {
    logic               rot_key;
    logic [1:0]         quad;
    logic signed [31:0] qf;
    logic signed [31:0] qs;
    logic signed [31:0] kf;
    logic signed [31:0] ks;
  } side_t;

  // One CORDIC cell's state.
  typedef struct packed {
    logic               vld;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    side_t              side;
  } cell_t;

  function automatic logic signed [33:0] atan_turns(input int i);
    logic signed [33:0] a;
    case (i)
      0: a = 34'sh20000000;   1: a = 34'sh12E4051E;  2: a = 34'sh09FB385B;
      3: a = 34'sh051111D4;   4: a = 34'sh028B0D43;  5: a = 34'sh0145D7E1;
      6: a = 34'sh00A2F61E;   7: a = 34'sh00517C55;  8: a = 34'sh0028BE53;
      9: a = 34'sh00145F2F;  10: a = 34'sh000A2F98; 11: a = 34'sh000517CC;
      12: a = 34'sh00028BE6; 13: a = 34'sh000145F3; 14: a = 34'sh0000A2FA;
      15: a = 34'sh0000517D; 16: a = 34'sh000028BE; 17: a = 34'sh0000145F;
      18: a = 34'sh00000A30; 19: a = 34'sh00000518; 20: a = 34'sh0000028C;
      21: a = 34'sh00000146; 22: a = 34'sh000000A3; 23: a = 34'sh00000051;
      24: a = 34'sh00000029; 25: a = 34'sh00000014; 26: a = 34'sh0000000A;
      27: a = 34'sh00000005; 28: a = 34'sh00000003; 29: a = 34'sh00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat_round(input logic signed [65:0] acc);
    logic signed [65:0] r;
    r = (acc + 66'sd536870912) >>> 30;
    if (r > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (r < -66'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

endpackage

[rtl/core/rope_cell.sv]
module rope_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  rope_pkg::cell_t  cell_in,
  output rope_pkg::cell_t  cell_out
);
  import rope_pkg::*;

  cell_t cell_r, cell_nxt;
  logic signed [33:0] xs, ys;

  always_comb begin
    xs = cell_in.x >>> STEP;
    ys = cell_in.y >>> STEP;
    cell_nxt = cell_in;
    if (!cell_in.z[33]) begin
      cell_nxt.x = cell_in.x - ys;
      cell_nxt.y = cell_in.y + xs;
      cell_nxt.z = cell_in.z - atan_turns(STEP);
    end else begin
      cell_nxt.x = cell_in.x + ys;
      cell_nxt.y = cell_in.y - xs;
      cell_nxt.z = cell_in.z + atan_turns(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;
endmodule

[rtl/core/rotary_position_embedding.sv]
// Rotary position embedding, one pair per request.
// Input channel in_*: a rotate request turns the query pair, and the key pair
// when head_index is under key_head_count and MAX_HEADS, by position *
// frequency turns. A load request (kind 1) writes one frequency table entry
// and yields no result. Output channel out_*: one result per rotate request,
// in request order. Throughput: one request per cycle unless stalled. Each
// request passes 36 register stages (table read, phase multiply, quadrant,
// 30 CORDIC cells, quadrant fix, multiply, round/saturate) to out_valid.
// The whole pipe advances together; when the receiver stalls with a result
// waiting the pipe freezes and in_ready stays low until that result is taken.
// Reset clears all valid flags and key_head_count; the table is undefined
// until loaded. Configuration: APB-style, key_head_count at address 0.
module rotary_position_embedding #(
  parameter int HEAD_PAIRS    = rope_pkg::HeadPairsDef,
  parameter int MAX_HEADS     = rope_pkg::MaxHeadsDef,
  parameter int POSITION_BITS = rope_pkg::PositionBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rope_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rope_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [1:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import rope_pkg::*;

  localparam int AddrBits = (HEAD_PAIRS > 1) ? $clog2(HEAD_PAIRS) : 1;

  // ---- configuration ----
  logic [6:0] key_heads_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'(4 * RegKeyHeadCount)) ? {25'd0, key_heads_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_heads_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == 2'(4 * RegKeyHeadCount)) begin
      key_heads_r <= cfg_pwdata[6:0];
    end
  end

  // Global advance: the whole pipe moves unless a finished result is stuck.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  logic acc;
  assign acc = in_valid && in_ready;

  // ---- stage 1: table read ----
  logic [31:0] freq_mem [HEAD_PAIRS];
  logic        s1_vld_r;
  logic [31:0] s1_freq_r;
  logic        s1_inrange_r;
  logic [POSITION_BITS-1:0] s1_pos_r;
  side_t       s1_side_r;
  logic        pair_ok;
  assign pair_ok = ({26'd0, in_data.pair_index} < 32'(HEAD_PAIRS));

  always_ff @(posedge clk) begin
    if (acc && in_data.kind == KindLoad && pair_ok)
      freq_mem[AddrBits'(in_data.pair_index)] <= in_data.freq_word;
    if (adv) begin
      s1_freq_r    <= freq_mem[AddrBits'(in_data.pair_index)];
      s1_inrange_r <= pair_ok;
      s1_pos_r     <= POSITION_BITS'(in_data.position);
      s1_side_r.rot_key <= ({26'd0, in_data.head_index} < {25'd0, key_heads_r}) &&
                           ({26'd0, in_data.head_index} < 32'(MAX_HEADS));
      s1_side_r.quad <= '0;
      s1_side_r.qf <= in_data.query_first;
      s1_side_r.qs <= in_data.query_second;
      s1_side_r.kf <= in_data.key_first;
      s1_side_r.ks <= in_data.key_second;
    end
  end

  // ---- stage 2: phase product ----
  logic        s2_vld_r;
  logic [31:0] s2_phase_r;
  side_t       s2_side_r;
  logic [31:0] freq_eff;
  assign freq_eff = s1_inrange_r ? s1_freq_r : 32'd0;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_phase_r <= 32'(freq_eff * {{(32-POSITION_BITS){1'b0}}, s1_pos_r});
      s2_side_r  <= s1_side_r;
    end
  end

  // ---- stage 3: quadrant split, chain head ----
  cell_t chain [CordicSteps+1];
  logic [31:0] ph_off;
  logic [1:0]  quad;
  logic [31:0] resid;
  assign ph_off = s2_phase_r + 32'h2000_0000;
  assign quad   = ph_off[31:30];
  assign resid  = s2_phase_r - {quad, 30'd0};

  cell_t head_r;
  side_t head_side;
  always_comb begin
    head_side      = s2_side_r;
    head_side.quad = quad;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0; s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r   <= acc && in_data.kind == KindRotate;
      s2_vld_r   <= s1_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else if (adv) begin
      head_r <= '{vld: s2_vld_r, x: CordicStartX, y: '0,
                  z: {{2{resid[31]}}, resid}, side: head_side};
    end
  end
  assign chain[0] = head_r;

  // Row of CORDIC cells, one micro-rotation each.
  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    rope_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .cell_in(chain[g]), .cell_out(chain[g+1])
    );
  end

  // ---- quadrant restore ----
  cell_t tail;
  assign tail = chain[CordicSteps];
  logic signed [33:0] c_v, s_v;
  always_comb begin
    case (tail.side.quad)
      2'd0:    begin c_v = tail.x;  s_v = tail.y;  end
      2'd1:    begin c_v = -tail.y; s_v = tail.x;  end
      2'd2:    begin c_v = -tail.x; s_v = -tail.y; end
      default: begin c_v = tail.y;  s_v = -tail.x; end
    endcase
  end
  logic               fx_vld_r;
  logic signed [33:0] fx_c_r, fx_s_r;
  side_t              fx_side_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      fx_c_r <= c_v; fx_s_r <= s_v; fx_side_r <= tail.side;
    end
  end

  // ---- products: eight 34x32 multiplies, registered ----
  logic               mp_vld_r;
  logic signed [65:0] p_r [8];
  side_t              mp_side_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= 66'(fx_c_r * fx_side_r.qf);
      p_r[1] <= 66'(fx_s_r * fx_side_r.qs);
      p_r[2] <= 66'(fx_s_r * fx_side_r.qf);
      p_r[3] <= 66'(fx_c_r * fx_side_r.qs);
      p_r[4] <= 66'(fx_c_r * fx_side_r.kf);
      p_r[5] <= 66'(fx_s_r * fx_side_r.ks);
      p_r[6] <= 66'(fx_s_r * fx_side_r.kf);
      p_r[7] <= 66'(fx_c_r * fx_side_r.ks);
      mp_side_r <= fx_side_r;
    end
  end

  // ---- round, saturate, output register ----
  out_item_t out_r;
  logic      out_vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_vld_r <= 1'b0; mp_vld_r <= 1'b0; out_vld_r <= 1'b0;
    end else if (adv) begin
      fx_vld_r  <= tail.vld;
      mp_vld_r  <= fx_vld_r;
      out_vld_r <= mp_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.query_first_out  <= sat_round(p_r[0] - p_r[1]);
      out_r.query_second_out <= sat_round(p_r[2] + p_r[3]);
      if (mp_side_r.rot_key) begin
        out_r.key_first_out  <= sat_round(p_r[4] - p_r[5]);
        out_r.key_second_out <= sat_round(p_r[6] + p_r[7]);
      end else begin
        out_r.key_first_out  <= mp_side_r.kf;
        out_r.key_second_out <= mp_side_r.ks;
      end
      out_r.key_rotated <= mp_side_r.rot_key;
    end
  end
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // ---- checks ----
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("accepted while pipe frozen");
  a_unrot_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.key_rotated |-> out_data.key_first_out == $past(mp_side_r.kf)
      || !$past(adv))
    else $error("unrotated key altered");
endmodule
